### hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// types and constants shared by the serial frame deframer modules
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int HDR_CNT_W = 2;
    localparam int TDATA_W  = 80;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CHECK   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD   = 2'd0,
        ST_OK        = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] device_id;
        logic [WORD_W-1:0] command_code;
        logic [WORD_W-1:0] payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] byte_index;
        logic [BYTE_W-1:0] received_checksum;
        logic [BYTE_W-1:0] computed_sum;
        logic              frame_end;
    } result_t;

endpackage

### hdl/sfd_in_stage.sv
// ----------------------------------------------------------------------------
// sfd_in_stage
// input register for received bytes, refilled in the cycle it is consumed
// ----------------------------------------------------------------------------
module sfd_in_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sfd_pkg::BYTE_W-1:0] s_tdata,   // rx_byte
    input  logic                       s_tuser,   // restart
    input  logic                       take,
    output logic                       item_valid,
    output sfd_pkg::in_item_t          item
);
    import sfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.rx_byte <= s_tdata;
            item_reg.restart <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/sfd_parse.sv
// ----------------------------------------------------------------------------
// sfd_parse
// frame state and single-pass parsing of one byte into at most one result
// ----------------------------------------------------------------------------
module sfd_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  sfd_pkg::in_item_t item,
    output logic              res_valid,
    output sfd_pkg::result_t  res
);
    import sfd_pkg::*;

    phase_t               phase_reg,   phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0]    id_reg,      id_next;
    logic [WORD_W-1:0]    cmd_reg,     cmd_next;
    logic [WORD_W-1:0]    len_reg,     len_next;
    logic [WORD_W-1:0]    pcnt_reg,    pcnt_next;
    logic [BYTE_W-1:0]    sum_reg,     sum_next;

    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    sum_add;
    phase_t               ph;

    assign b       = item.rx_byte;
    assign sum_add = sum_reg + b;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        id_next      = id_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        pcnt_next    = pcnt_reg;
        sum_next     = sum_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.device_id      = id_reg;
        res.command_code   = cmd_reg;
        res.payload_length = len_reg;
        res.computed_sum   = sum_reg;
        ph           = phase_reg;

        // restart drops a partial frame and reports it
        if (item.restart)
        begin
            if (phase_reg != PH_HUNT)
            begin
                res_valid      = 1'b1;
                res.status     = ST_TRUNCATED;
                res.byte_index = pcnt_reg;
                res.frame_end  = 1'b1;
            end
            ph           = PH_HUNT;
            phase_next   = PH_HUNT;
            hdr_cnt_next = '0;
        end

        unique case (ph)
            PH_HEADER:
            begin
                sum_next = sum_add;
                if (!hdr_cnt_reg[1])
                    cmd_next = {cmd_reg[BYTE_W-1:0], b};
                else
                    len_next = {len_reg[BYTE_W-1:0], b};
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == '1)
                begin
                    phase_next = (len_next == '0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_next         = sum_add;
                res_valid        = 1'b1;
                res.status       = ST_PAYLOAD;
                res.payload_byte = b;
                res.byte_index   = pcnt_reg;
                res.computed_sum = sum_add;
                pcnt_next        = pcnt_reg + 1'b1;
                if (pcnt_next >= len_reg)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                res_valid             = 1'b1;
                res.status            = (b == sum_reg) ? ST_OK : ST_MISMATCH;
                res.received_checksum = b;
                res.frame_end         = 1'b1;
                phase_next            = PH_HUNT;
                hdr_cnt_next          = '0;
            end
            PH_HUNT:
            begin
                // start bytes are skipped, anything else opens a frame
                if (b != START_BYTE)
                begin
                    id_next      = b;
                    cmd_next     = '0;
                    len_next     = '0;
                    pcnt_next    = '0;
                    sum_next     = b;
                    hdr_cnt_next = '0;
                    phase_next   = PH_HEADER;
                end
            end
            default:
            begin
                phase_next   = PH_HUNT;
                hdr_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            hdr_cnt_reg <= '0;
            id_reg      <= '0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            pcnt_reg    <= '0;
            sum_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            id_reg      <= id_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            pcnt_reg    <= pcnt_next;
            sum_reg     <= sum_next;
        end
    end

    // header counter only runs inside the header
    a_hdr_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEADER |-> hdr_cnt_reg == '0)
        else $error("header count nonzero outside header");

    // payload phase never has all bytes already counted
    a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pcnt_reg < len_reg)
        else $error("payload count reached length in payload phase");

    // a checksum byte always closes the frame with a result
    a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_CHECK && !item.restart
            |-> res_valid && res.frame_end && phase_next == PH_HUNT)
        else $error("checksum byte did not end the frame");

endmodule

### hdl/serial_frame_deframer_sum8.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_sum8
// cuts a stream of received serial bytes into frames with an 8-bit sum check
// ----------------------------------------------------------------------------
// usage
//   slave channel: one received byte per transfer, tuser carries restart,
//   which drops any partial frame before that byte
//   master channel: one result per payload byte (tuser = payload status) and
//   one frame-end result per frame (tlast high, tuser = ok, mismatch or
//   truncated); start bytes and header bytes give no result
//   path: a byte is registered at the input, parsed in one pass and its
//   result is registered in the result register before it is presented
//   throughput: one byte per cycle while no result is held by the output,
//   with a combinational parse between the input and result registers
//   reset: returns the parser to hunting for a frame start, all counters
//   and header fields cleared, both registers empty
//   stall: a held result keeps the parser still; the input register still
//   takes one more byte, then s_tready drops until the result is taken
// ----------------------------------------------------------------------------
module serial_frame_deframer_sum8
(
    input  logic                        clk,
    input  logic                        rst_n,
    // received bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sfd_pkg::BYTE_W-1:0]  s_tdata,   // rx_byte[7:0]
    input  logic                        s_tuser,   // restart
    // parse results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // device_id[7:0], command_code[23:8], payload_length[39:24],
    // payload_byte[47:40], byte_index[63:48], received_checksum[71:64],
    // computed_sum[79:72]
    output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // status[1:0]
    output logic                        m_tlast    // frame_end
);
    import sfd_pkg::*;

    in_item_t item;
    logic     item_valid;
    logic     take;
    logic     res_valid;
    result_t  res;

    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_reg;
    logic     out_free;

    // the parser moves only when the result register can take its output
    assign out_free = !out_valid_reg || m_tready;
    assign take     = item_valid && out_free;

    sfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sfd_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    assign out_valid_next = (take && res_valid) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {out_reg.computed_sum,
                       out_reg.received_checksum,
                       out_reg.byte_index,
                       out_reg.payload_byte,
                       out_reg.payload_length,
                       out_reg.command_code,
                       out_reg.device_id};

    // a held result must freeze the parser
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !take)
        else $error("parser advanced while result stalled");

    // input back-pressure only while a byte is waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid && !out_free)
        else $error("input stalled without a waiting byte");

    // frame end exactly on the non-payload statuses
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (out_reg.status != ST_PAYLOAD)))
        else $error("tlast disagrees with status");

endmodule
